FILE: sv/oaht_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the open-address hash table.
// No dependencies; the top module and the remainder unit import this package.
package oaht_pkg;

   // Default number of slots (a prime)
   localparam int TABLE_SIZE_DEF = 13;

   // Field widths
   localparam int KEY_W     = 31;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 4;
   localparam int COUNT_W   = 32;
   localparam int ENTRY_W   = KEY_W + 1;   // used flag + stored value

   // Remainder unit: key bits (one digit) consumed per cycle
   localparam int DIGIT_W   = 4;
   localparam int STEPS     = (KEY_W + DIGIT_W - 1) / DIGIT_W;
   localparam int PAD_W     = STEPS * DIGIT_W;
   localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   // Command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Probe mode codes
   localparam logic MODE_QUAD   = 1'b0;
   localparam logic MODE_DOUBLE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

FILE: sv/open_address_hash_table_top.sv
`timescale 1ns / 1ps
// Open-address hash table: request, response and one-register control port.
// Requests (req_cmd, req_key_value) enter on req_valid while req_stall is low;
// req_cmd selects insert or lookup. Each request yields exactly one response
// word (rsp_status, rsp_slot_index, rsp_collision_total) on rsp_valid, held
// until a cycle with rsp_stall low. csr_wr_en/csr_wr_data set the probe mode
// (0 quadratic, 1 double hashing); write it only while the table is idle.
// Flow: the request is accepted, the remainder unit reduces the key (4 bits a
// cycle), the home slot is read, then the slots are probed one at a time through
// the slot memory's single read port, pausing while the output register is full;
// k probes, 1 <= k <= TABLE_SIZE. One request is in flight at a time; the next is taken
// once the previous response sits in the output register.
// Reset (synchronous, active high) starts a clearing pass that writes every slot
// of the slot memory, during which req_stall is high; the collision count
// clears and the probe mode returns to double hashing.
// A stalled response holds; the probe unit waits on its final probe until the
// output register is free, so nothing is dropped.
module open_address_hash_table_top
   import oaht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [KEY_W-1:0]    req_key_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_index,
   output logic [COUNT_W-1:0]  rsp_collision_total,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W:0]   SIZE_X = (IDX_W+1)'(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST   = IDX_W'(TABLE_SIZE - 1);

   typedef enum logic [1:0] {
      CLEAR,
      IDLE,
      HASH,
      PROBE
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]      probe_ff, probe_in;
   logic [IDX_W-1:0]      inc_ff, inc_in;
   logic [IDX_W-1:0]      stride_ff, stride_in;
   logic                  cmd_ff, cmd_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic                  mode_ff, mode_in;
   logic [COUNT_W-1:0]    coll_ff, coll_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]    rsp_coll_ff, rsp_coll_in;

   logic                  accept;
   logic                  out_free;
   logic                  hash_done;
   logic [IDX_W-1:0]      hash_home;
   logic [IDX_W-1:0]      hash_rem;
   logic                  wr_en;
   logic [ENTRY_W-1:0]    wr_data;
   logic [ENTRY_W-1:0]    rd_data;
   logic                  slot_used;
   logic [KEY_W-1:0]      slot_key;
   logic [IDX_W-1:0]      step;
   logic [IDX_W:0]        pos_sum;
   logic [IDX_W:0]        inc_sum;
   logic                  last_probe;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_used = rd_data[KEY_W];
   assign slot_key  = rd_data[KEY_W-1:0];

   // Remainders for home slot and double-hash stride
   oaht_mod_unit #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .key     (req_key_value),
      .done    (hash_done),
      .home    (hash_home),
      .rem_step(hash_rem)
   );

   // Slot memory: used flag over stored value; read address follows next position
   oaht_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_SIZE)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pos_ff),
      .wr_data(wr_data),
      .rd_addr(pos_in),
      .rd_data(rd_data)
   );

   // Next probe position and quadratic increment, both reduced mod TABLE_SIZE
   always_comb begin
      step = (mode_ff == MODE_QUAD) ? inc_ff : stride_ff;
      pos_sum = {1'b0, pos_ff} + {1'b0, step};
      if (pos_sum >= SIZE_X) begin
         pos_sum = pos_sum - SIZE_X;
      end
      inc_sum = {1'b0, inc_ff} + (IDX_W+1)'(2);
      if (inc_sum >= SIZE_X) begin
         inc_sum = inc_sum - SIZE_X;
      end
   end

   assign last_probe = (probe_ff == LAST);

   // Control: clearing pass, request intake, probe walk
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      probe_in      = probe_ff;
      inc_in        = inc_ff;
      stride_in     = stride_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      mode_in       = mode_ff;
      coll_in       = coll_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_coll_in   = rsp_coll_ff;
      wr_en         = 1'b0;
      wr_data       = '0;

      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         CLEAR: begin
            wr_en = 1'b1;
            if (pos_ff == LAST) begin
               pos_in   = '0;
               state_in = IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               key_in   = req_key_value;
               state_in = HASH;
            end
         end
         HASH: begin
            if (hash_done) begin
               pos_in    = hash_home;
               stride_in = hash_rem + 1'b1;
               inc_in    = IDX_W'(1);
               probe_in  = '0;
               state_in  = PROBE;
            end
         end
         PROBE: begin
            if (out_free) begin
               if (cmd_ff == CMD_INSERT) begin
                  if (!slot_used) begin
                     wr_en         = 1'b1;
                     wr_data       = {1'b1, key_ff};
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_INSERTED;
                     rsp_slot_in   = SLOT_W'(pos_ff);
                     rsp_coll_in   = coll_ff;
                     state_in      = IDLE;
                  end else begin
                     coll_in = coll_ff + 1'b1;
                     if (last_probe) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                        rsp_slot_in   = '0;
                        rsp_coll_in   = coll_in;
                        state_in      = IDLE;
                     end else begin
                        pos_in   = pos_sum[IDX_W-1:0];
                        inc_in   = inc_sum[IDX_W-1:0];
                        probe_in = probe_ff + 1'b1;
                     end
                  end
               end else begin
                  if (!slot_used || last_probe || slot_key == key_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_coll_in  = coll_ff;
                     state_in     = IDLE;
                     if (slot_used && slot_key == key_ff) begin
                        rsp_status_in = ST_FOUND;
                        rsp_slot_in   = SLOT_W'(pos_ff);
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                        rsp_slot_in   = '0;
                     end
                  end else begin
                     pos_in   = pos_sum[IDX_W-1:0];
                     inc_in   = inc_sum[IDX_W-1:0];
                     probe_in = probe_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Hold state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         pos_ff       <= '0;
         mode_ff      <= MODE_DOUBLE;
         coll_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         mode_ff      <= mode_in;
         coll_ff      <= coll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      probe_ff      <= probe_in;
      inc_ff        <= inc_in;
      stride_ff     <= stride_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_coll_ff   <= rsp_coll_in;
   end

   assign req_stall           = (state_ff != IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_collision_total = rsp_coll_ff;

endmodule

FILE: sv/oaht_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module oaht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/oaht_mod_unit.sv
`timescale 1ns / 1ps
// Iterative remainder unit: key mod TABLE_SIZE and key mod (TABLE_SIZE-1),
// DIGIT_W (4) key bits per cycle while busy. Depends on oaht_pkg.
module oaht_mod_unit
   import oaht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_W-1:0]              key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] home,
   output logic [$clog2(TABLE_SIZE)-1:0] rem_step
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W:0] MOD_HOME = (IDX_W+1)'(TABLE_SIZE);
   localparam logic [IDX_W:0] MOD_STEP = (IDX_W+1)'(TABLE_SIZE - 1);

   logic [PAD_W-1:0]      sh_ff, sh_in;
   logic [IDX_W-1:0]      r1_ff, r1_in;
   logic [IDX_W-1:0]      r2_ff, r2_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   // Shift in one digit: remainder = (2*remainder + bit) reduced, bit by bit
   always_comb begin
      logic [IDX_W:0] t1;
      logic [IDX_W:0] t2;
      t1 = {1'b0, r1_ff};
      t2 = {1'b0, r2_ff};
      for (int i = 0; i < DIGIT_W; i++) begin
         t1 = {t1[IDX_W-1:0], sh_ff[PAD_W-1-i]};
         if (t1 >= MOD_HOME) begin
            t1 = t1 - MOD_HOME;
         end
         t2 = {t2[IDX_W-1:0], sh_ff[PAD_W-1-i]};
         if (t2 >= MOD_STEP) begin
            t2 = t2 - MOD_STEP;
         end
      end

      sh_in   = sh_ff;
      r1_in   = r1_ff;
      r2_in   = r2_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         sh_in   = PAD_W'(key);
         r1_in   = '0;
         r2_in   = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in  = sh_ff << DIGIT_W;
         r1_in  = t1[IDX_W-1:0];
         r2_in  = t2[IDX_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Hold datapath
   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
      r1_ff <= r1_in;
      r2_ff <= r2_in;
   end

   assign done     = done_ff;
   assign home     = r1_ff;
   assign rem_step = r2_ff;

endmodule
